// ----- rtl/dcms_pkg.sv -----
// dcms_pkg: shared widths, op codes, register map and types for the
// depth composite mismatch scorer. No dependencies.
package dcms_pkg;

   localparam int OP_W       = 2;
   localparam int ROW_W      = 9;
   localparam int COL_W      = 10;
   localparam int DEPTH_W    = 16;
   localparam int COUNT_W    = 19;
   localparam int THR_W      = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [THR_W-1:0]   THR_RESET = 16'd100;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // register word index (byte address / 4)
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 1'b0;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD    = 2'd0,
      OP_MERGE   = 2'd1,
      OP_COMPARE = 2'd2
   } op_type;

   // per-item update handed from the pixel pipeline to the score counter
   typedef struct packed {
      logic valid;   // compare item in the last stage
      logic hit;     // pixel counts as a mismatch
      logic last;    // frame_end: emit and clear
   } score_upd_type;

endpackage

// ----- rtl/dcms_if.sv -----
// Valid/ready channel interfaces for the pixel item and the score item.
// Depends on dcms_pkg for field widths.
interface dcms_req_if;
   logic                         valid;
   logic                         ready;
   logic [dcms_pkg::OP_W-1:0]    op;
   logic [dcms_pkg::ROW_W-1:0]   row;
   logic [dcms_pkg::COL_W-1:0]   column;
   logic [dcms_pkg::DEPTH_W-1:0] depth;
   logic                         frame_end;

   modport source (output valid, op, row, column, depth, frame_end, input ready);
   modport sink   (input valid, op, row, column, depth, frame_end, output ready);
endinterface

interface dcms_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dcms_pkg::COUNT_W-1:0] mismatch_count;

   modport source (output valid, mismatch_count, input ready);
   modport sink   (input valid, mismatch_count, output ready);
endinterface

// ----- rtl/dcms_csr.sv -----
// dcms_csr: APB-style register file holding the mismatch threshold.
// Depends on dcms_pkg.
module dcms_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [dcms_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [dcms_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [dcms_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output logic [dcms_pkg::THR_W-1:0]      threshold
);

   logic [dcms_pkg::CSR_IDX_W-1:0] word_idx;
   logic [dcms_pkg::THR_W-1:0]     thr_ff, thr_in;

   assign word_idx = paddr[dcms_pkg::CSR_ADDR_W-1:2];
   assign pready   = 1'b1;

   always_comb begin
      thr_in = thr_ff;
      if (psel && penable && pwrite && word_idx == dcms_pkg::REG_THRESHOLD) begin
         thr_in = pwdata[dcms_pkg::THR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= dcms_pkg::THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign prdata    = (word_idx == dcms_pkg::REG_THRESHOLD) ?
                      dcms_pkg::CSR_DATA_W'(thr_ff) : '0;
   assign threshold = thr_ff;

endmodule

// ----- rtl/dcms_depth_mem.sv -----
// dcms_depth_mem: single-port-write, single-port-read depth image store,
// registered read data. Depends on dcms_pkg.
module dcms_depth_mem #(
   parameter int DEPTH  = 307200,
   parameter int ADDR_W = 19
) (
   input  logic                         clock,
   input  logic                         we,
   input  logic [ADDR_W-1:0]            waddr,
   input  logic [dcms_pkg::DEPTH_W-1:0] wdata,
   input  logic                         re,
   input  logic [ADDR_W-1:0]            raddr,
   output logic [dcms_pkg::DEPTH_W-1:0] rdata
);

   logic [dcms_pkg::DEPTH_W-1:0] store_mem [DEPTH];
   logic [dcms_pkg::DEPTH_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_mem[waddr] <= wdata;
      end
   end

   // read sees the old entry when the same address is written this cycle
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= store_mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/dcms_score.sv -----
// dcms_score: saturating mismatch counter and result register.
// Depends on dcms_pkg and dcms_rsp_if.
module dcms_score (
   input  logic                    clock,
   input  logic                    reset,
   input  dcms_pkg::score_upd_type upd,
   output logic                    blocked,
   dcms_rsp_if.source              rsp_chan
);

   logic [dcms_pkg::COUNT_W-1:0] acc_ff, acc_in, acc_sum;
   logic [dcms_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // a frame-ending item cannot land while the previous score is unclaimed
   assign blocked = upd.valid && upd.last && rsp_valid_ff && !rsp_chan.ready;

   assign acc_sum = (upd.hit && acc_ff != dcms_pkg::COUNT_MAX) ?
                    acc_ff + dcms_pkg::COUNT_W'(1) : acc_ff;

   always_comb begin
      acc_in       = acc_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (upd.valid && !blocked) begin
         acc_in = acc_sum;
         if (upd.last) begin
            acc_in       = '0;
            count_in     = acc_sum;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.mismatch_count = count_ff;

endmodule

// ----- rtl/depth_composite_mismatch_score.sv -----
// depth_composite_mismatch_score: top level; pixel pipeline around the depth
// image store. Depends on dcms_pkg, dcms_if, dcms_csr, dcms_depth_mem, dcms_score.
//
//   port       dir   handshake                payload
//   ---------  ----  -----------------------  ---------------------------------
//   req_chan   in    valid/ready              op, row, column, depth, frame_end
//   rsp_chan   out   valid/ready              mismatch_count
//   APB        in    psel&penable&pwrite      paddr, pwdata -> prdata
//
// One item per clock unless stalled or clearing. Path from accept to result valid:
// index multiply, memory read, modify/write-back, then the score result register.
// The memory read-modify-write runs over two stages; a write in the last stage
// is forwarded to the item right behind it when both touch the same pixel.
// After reset a clearing pass zeroes the image, one pixel a cycle, over all
// IMAGE_WIDTH*IMAGE_HEIGHT pixels (307200 at 640x480); req_chan.ready stays low.
// The pipeline stalls only when a frame-ending compare item meets a result register
// that still holds an unclaimed score.
module depth_composite_mismatch_score #(
   parameter int IMAGE_WIDTH  = 640,
   parameter int IMAGE_HEIGHT = 480
) (
   input  logic                            clock,
   input  logic                            reset,
   dcms_req_if.sink                        req_chan,
   dcms_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [dcms_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [dcms_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [dcms_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   localparam int PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
   localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int LIN_W  = ADDR_W + dcms_pkg::COL_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXELS - 1);

   // stage 1: raw item as accepted
   typedef struct packed {
      logic [dcms_pkg::OP_W-1:0]    op;
      logic [dcms_pkg::ROW_W-1:0]   row;
      logic [dcms_pkg::COL_W-1:0]   column;
      logic [dcms_pkg::DEPTH_W-1:0] depth;
      logic                         last;
   } raw_stage_type;

   // stages 2 and 3: linear pixel address resolved
   typedef struct packed {
      logic [dcms_pkg::OP_W-1:0]    op;
      logic [ADDR_W-1:0]            idx;
      logic                         inrange;
      logic [dcms_pkg::DEPTH_W-1:0] depth;
      logic                         last;
   } pix_stage_type;

   logic                         clearing_ff, clearing_in;
   logic [ADDR_W-1:0]            clr_addr_ff, clr_addr_in;
   logic                         advance, blocked, accept;

   logic                         v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   raw_stage_type                s1_ff, s1_in;
   pix_stage_type                s2_ff, s2_in, s3_ff, s3_in;
   logic                         fwd_hit_ff, fwd_hit_in;
   logic [dcms_pkg::DEPTH_W-1:0] fwd_data_ff, fwd_data_in;

   logic [LIN_W-1:0]             s1_lin;
   logic                         s1_inrange;

   logic [dcms_pkg::DEPTH_W-1:0] rd_data, s3_stored, s3_diff;
   logic                         s3_we, s3_hit;
   logic                         mem_we, mem_re;
   logic [ADDR_W-1:0]            mem_waddr;
   logic [dcms_pkg::DEPTH_W-1:0] mem_wdata;
   logic [dcms_pkg::THR_W-1:0]   threshold;
   dcms_pkg::score_upd_type      upd;

   dcms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .threshold (threshold)
   );

   // ---------------- clearing pass after reset ----------------
   always_comb begin
      clearing_in = clearing_ff && (clr_addr_ff != LAST_ADDR);
      clr_addr_in = clearing_ff ? clr_addr_ff + ADDR_W'(1) : clr_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // ---------------- flow control ----------------
   assign advance        = !blocked;
   assign req_chan.ready = advance && !clearing_ff;
   assign accept         = req_chan.valid && req_chan.ready;

   // ---------------- stage 1: pixel index ----------------
   assign s1_lin = LIN_W'(s1_ff.row) * LIN_W'(IMAGE_WIDTH) + LIN_W'(s1_ff.column);
   assign s1_inrange = (32'(s1_ff.row) < IMAGE_HEIGHT) &&
                       (32'(s1_ff.column) < IMAGE_WIDTH);

   // ---------------- stage 3: modify ----------------
   // stored value: forwarded write from the item just ahead, else memory
   assign s3_stored = fwd_hit_ff ? fwd_data_ff : rd_data;
   assign s3_diff   = (s3_ff.depth > s3_stored) ? s3_ff.depth - s3_stored :
                                                  s3_stored - s3_ff.depth;

   always_comb begin
      s3_we  = 1'b0;
      s3_hit = 1'b0;
      unique case (dcms_pkg::op_type'(s3_ff.op))
         dcms_pkg::OP_LOAD: begin
            s3_we = v3_ff && s3_ff.inrange;
         end
         dcms_pkg::OP_MERGE: begin
            // nearer nonzero depth wins; empty pixel always takes it
            s3_we = v3_ff && s3_ff.inrange && (s3_ff.depth != '0) &&
                    ((s3_stored == '0) || (s3_ff.depth < s3_stored));
         end
         dcms_pkg::OP_COMPARE: begin
            s3_hit = s3_ff.inrange && ((s3_ff.depth != '0) || (s3_stored != '0)) &&
                     (s3_diff > threshold);
         end
         default: begin
         end
      endcase
   end

   assign upd.valid = v3_ff && (s3_ff.op == dcms_pkg::OP_COMPARE);
   assign upd.hit   = s3_hit;
   assign upd.last  = s3_ff.last;

   // ---------------- stage advance ----------------
   always_comb begin
      v1_in       = v1_ff;
      v2_in       = v2_ff;
      v3_in       = v3_ff;
      s1_in       = s1_ff;
      s2_in       = s2_ff;
      s3_in       = s3_ff;
      fwd_hit_in  = fwd_hit_ff;
      fwd_data_in = fwd_data_ff;
      if (advance) begin
         v1_in          = accept;
         s1_in.op       = req_chan.op;
         s1_in.row      = req_chan.row;
         s1_in.column   = req_chan.column;
         s1_in.depth    = req_chan.depth;
         s1_in.last     = req_chan.frame_end;

         v2_in          = v1_ff;
         s2_in.op       = s1_ff.op;
         s2_in.idx      = s1_lin[ADDR_W-1:0];
         s2_in.inrange  = s1_inrange;
         s2_in.depth    = s1_ff.depth;
         s2_in.last     = s1_ff.last;

         v3_in          = v2_ff;
         s3_in          = s2_ff;

         // read in flight misses the write landing at this same edge
         fwd_hit_in     = v2_ff && s2_ff.inrange && s3_we && (s2_ff.idx == s3_ff.idx);
         fwd_data_in    = s3_ff.depth;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         v1_ff      <= v1_in;
         v2_ff      <= v2_in;
         v3_ff      <= v3_in;
         fwd_hit_ff <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      s3_ff       <= s3_in;
      fwd_data_ff <= fwd_data_in;
   end

   // ---------------- depth image store ----------------
   assign mem_re    = advance && v2_ff;
   assign mem_we    = clearing_ff || (s3_we && advance);
   assign mem_waddr = clearing_ff ? clr_addr_ff : s3_ff.idx;
   assign mem_wdata = clearing_ff ? '0 : s3_ff.depth;

   dcms_depth_mem #(
      .DEPTH  (PIXELS),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (s2_ff.idx),
      .rdata (rd_data)
   );

   // ---------------- score counter and result register ----------------
   dcms_score u_score (
      .clock    (clock),
      .reset    (reset),
      .upd      (upd),
      .blocked  (blocked),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- rtl/dcms_checker.sv -----
// dcms_checker: port-level assertions for the mismatch scorer, bound to the
// top level. Depends on dcms_pkg, dcms_if, depth_composite_mismatch_score.
module dcms_checker (
   input  logic                            clock,
   input  logic                            reset,
   dcms_req_if.sink                        req_chan,
   dcms_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [dcms_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [dcms_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic [dcms_pkg::CSR_DATA_W-1:0] prdata,
   input  logic                            pready
);

   // reset starts the clearing pass: no items taken, no score shown
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_chan.ready && !rsp_chan.valid)
      else $error("item accepted or score shown right after reset");

   // an unclaimed score holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid &&
      $stable(rsp_chan.mismatch_count))
      else $error("score dropped or changed while stalled");

   // once running, input backpressure only comes from a stalled score
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(req_chan.ready) && !req_chan.ready |->
      rsp_chan.valid && !rsp_chan.ready)
      else $error("input stalled without a pending score");

   // threshold write reads back on the next cycle
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready &&
      paddr[dcms_pkg::CSR_ADDR_W-1:2] == dcms_pkg::REG_THRESHOLD |=>
      (paddr[dcms_pkg::CSR_ADDR_W-1:2] != dcms_pkg::REG_THRESHOLD) ||
      (prdata == dcms_pkg::CSR_DATA_W'($past(pwdata[dcms_pkg::THR_W-1:0]))))
      else $error("threshold readback mismatch");

endmodule

bind depth_composite_mismatch_score dcms_checker u_dcms_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan),
   .psel     (psel),
   .penable  (penable),
   .pwrite   (pwrite),
   .paddr    (paddr),
   .pwdata   (pwdata),
   .prdata   (prdata),
   .pready   (pready)
);
